[rtl/wbcs_pkg.sv]
// ----------------------------------------------------------------------------
// wbcs_pkg
// Shared types and constants of the bright-blob centroid steering block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wbcs_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned ColW   = 12;
  localparam int unsigned SumW   = 36;
  localparam int unsigned CntW   = 24;
  localparam int unsigned OutW   = 16;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned RegDatW = 16;
  localparam int unsigned MagW   = 13;
  localparam int unsigned PiW    = 31;
  localparam int unsigned ProdW  = MagW + PiW;

  localparam int unsigned JobDepth = 2;

  localparam logic [RegIdxW-1:0] RegRowStride  = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegMatchValue = RegIdxW'(1);

  localparam logic [ColW-1:0] StrideReset = ColW'(1920);
  localparam logic [PixW-1:0] MatchReset  = PixW'(255);

  localparam logic [PiW-1:0]  PiQ29    = PiW'(1686629713);
  localparam logic [OutW-1:0] SpeedOne = OutW'(32768);
  localparam logic [OutW-1:0] SpeedMin = OutW'(3277);
  localparam logic [ColW-1:0] AvgMax   = ColW'(4095);

  typedef struct packed {
    logic [PixW-1:0] pixel_byte;
    logic            end_of_frame;
  } pix_t;

  typedef struct packed {
    logic                   target_seen;
    logic signed [OutW-1:0] turn_rate;
    logic [OutW-1:0]        forward_speed;
  } res_t;

  typedef struct packed {
    logic [RegIdxW-1:0] reg_idx;
    logic [RegDatW-1:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [SumW-1:0] col_sum;
    logic [CntW-1:0] hit_cnt;
    logic [ColW-1:0] stride;
  } job_t;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/wbcs_stream_if.sv]
// ----------------------------------------------------------------------------
// wbcs_stream_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wbcs_stream_if #(
  parameter type data_t = logic
) ();

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/wbcs_div.sv]
// ----------------------------------------------------------------------------
// wbcs_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbcs_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wbcs_pkg::div_req_t  req_i,
  output wbcs_pkg::div_rsp_t       rsp_o
);

  localparam int unsigned DvdW  = wbcs_pkg::SumW;
  localparam int unsigned DvsW  = wbcs_pkg::CntW;
  localparam int unsigned StepW = $clog2(DvdW);

  logic              busy_q;
  logic              done_q;
  logic [StepW-1:0]  step_q;
  logic [DvdW-1:0]   dvd_q;
  logic [DvsW-1:0]   dvs_q;
  logic [DvsW-1:0]   rem_q;
  logic [DvsW:0]     rem_sh;
  logic [DvsW:0]     rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, dvd_q[DvdW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= ge ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
      dvd_q <= {dvd_q[DvdW-2:0], ge};
    end else if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

`ifndef SYNTHESIS
  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

[rtl/wbcs_fifo.sv]
// ----------------------------------------------------------------------------
// wbcs_fifo
// Short job queue between the pixel front end and the result back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbcs_fifo #(
  parameter int unsigned DEPTH = wbcs_pkg::JobDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire wbcs_pkg::job_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output wbcs_pkg::job_t      head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FillW = $clog2(DEPTH + 1);

  wbcs_pkg::job_t   mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = fill_q == FillW'(DEPTH);
  assign valid_o = fill_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FillW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("job pushed into full queue");
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(DEPTH))
    else $error("queue fill beyond depth");
`endif

endmodule

`default_nettype wire

[rtl/wbcs_front.sv]
// ----------------------------------------------------------------------------
// wbcs_front
// Column tracking and match accumulation; one frame job per end-of-frame beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbcs_front (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  wbcs_stream_if.sink    pix_i,
  wbcs_stream_if.sink    cfg_i,
  output logic           push_o,
  output wbcs_pkg::job_t job_o,
  input  wire logic      full_i
);

  localparam int unsigned ColW = wbcs_pkg::ColW;
  localparam int unsigned SumW = wbcs_pkg::SumW;
  localparam int unsigned CntW = wbcs_pkg::CntW;

  logic [ColW-1:0]            row_stride_q;
  logic [wbcs_pkg::PixW-1:0]  match_value_q;
  logic [ColW-1:0]            col_q;
  logic [SumW-1:0]            sum_q;
  logic [CntW-1:0]            cnt_q;

  logic [ColW-1:0] stride;
  logic            hit;
  logic            take;
  logic [SumW:0]   sum_ext;
  logic [SumW-1:0] sum_d;
  logic [CntW-1:0] cnt_d;
  logic [ColW-1:0] col_d;
  logic [ColW:0]   col_inc;

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = !full_i;
  assign take        = pix_i.valid && pix_i.ready;

  assign stride  = (row_stride_q == '0) ? ColW'(1) : row_stride_q;
  assign hit     = pix_i.data.pixel_byte == match_value_q;
  assign sum_ext = {1'b0, sum_q} + (SumW + 1)'(col_q);
  assign col_inc = {1'b0, col_q} + (ColW + 1)'(1);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (hit) begin
      sum_d = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
      cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + CntW'(1);
    end
    col_d = (col_inc >= {1'b0, stride}) ? '0 : col_inc[ColW-1:0];
  end

  assign push_o        = take && pix_i.data.end_of_frame;
  assign job_o.col_sum = sum_d;
  assign job_o.hit_cnt = cnt_d;
  assign job_o.stride  = stride;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_stride_q  <= wbcs_pkg::StrideReset;
      match_value_q <= wbcs_pkg::MatchReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_idx)
        wbcs_pkg::RegRowStride:  row_stride_q  <= cfg_i.data.wdata[ColW-1:0];
        wbcs_pkg::RegMatchValue: match_value_q <= cfg_i.data.wdata[wbcs_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (take) begin
      if (pix_i.data.end_of_frame) begin
        col_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        col_q <= col_d;
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/wbcs_back.sv]
// ----------------------------------------------------------------------------
// wbcs_back
// Per-frame average, error, turn rate and speed on a shared serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbcs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  wire wbcs_pkg::job_t job_i,
  output logic                pop_o,
  wbcs_stream_if.source       res_o
);

  localparam int unsigned ColW  = wbcs_pkg::ColW;
  localparam int unsigned SumW  = wbcs_pkg::SumW;
  localparam int unsigned CntW  = wbcs_pkg::CntW;
  localparam int unsigned MagW  = wbcs_pkg::MagW;
  localparam int unsigned ProdW = wbcs_pkg::ProdW;
  localparam int unsigned OutW  = wbcs_pkg::OutW;
  localparam int unsigned SpdDvdW = MagW + 16;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AVG  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_TISS = 3'd3;
  localparam logic [2:0] S_TDIV = 3'd4;
  localparam logic [2:0] S_SDIV = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [ColW-1:0]        stride_q;
  logic                   neg_q;
  logic [MagW-1:0]        mag_q;
  logic [ProdW-1:0]       prod_q;
  wbcs_pkg::res_t         work_q, work_d;
  wbcs_pkg::res_t         out_q;
  logic                   out_vld_q;

  wbcs_pkg::div_req_t     div_req;
  wbcs_pkg::div_rsp_t     div_rsp;

  logic [SumW-1:0]        quo;
  logic                   quo_big;
  logic [ColW-1:0]        avg;
  logic signed [MagW:0]   err;
  logic [SpdDvdW-1:0]     spd_dvd;
  logic [OutW-1:0]        spd_raw;
  logic                   load_out;

  wbcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign quo     = div_rsp.quotient;
  assign quo_big = quo[SumW-1:15] != '0;
  assign avg     = (quo[SumW-1:ColW] != '0) ? wbcs_pkg::AvgMax : quo[ColW-1:0];
  assign err     = $signed({2'b00, stride_q}) - $signed({1'b0, avg, 1'b0});
  assign spd_dvd = (SpdDvdW'(mag_q) << 15) + SpdDvdW'(stride_q) - SpdDvdW'(1);
  assign spd_raw = wbcs_pkg::SpeedOne - {1'b0, quo[14:0]};
  assign load_out = (state_q == S_DONE) && (!out_vld_q || res_o.ready);

  always_comb begin
    state_d          = state_q;
    work_d           = work_q;
    pop_o            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = job_i.col_sum;
    div_req.divisor  = job_i.hit_cnt;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          if (job_i.hit_cnt == '0) begin
            work_d  = '0;
            state_d = S_DONE;
          end else begin
            div_req.start = 1'b1;
            state_d       = S_AVG;
          end
        end
      end
      S_AVG: begin
        if (div_rsp.done) state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_TISS;
      end
      S_TISS: begin
        div_req.start    = 1'b1;
        div_req.dividend = SumW'(prod_q[ProdW-1:16]);
        div_req.divisor  = CntW'(stride_q);
        state_d          = S_TDIV;
      end
      S_TDIV: begin
        div_req.dividend = SumW'(spd_dvd);
        div_req.divisor  = CntW'(stride_q);
        if (div_rsp.done) begin
          work_d.target_seen = 1'b1;
          if (neg_q) begin
            work_d.turn_rate = quo_big ? OutW'(16'sh8000) : OutW'(-quo[OutW-1:0]);
          end else begin
            work_d.turn_rate = quo_big ? OutW'(16'sh7FFF) : OutW'(quo[OutW-1:0]);
          end
          div_req.start = 1'b1;
          state_d       = S_SDIV;
        end
      end
      S_SDIV: begin
        if (div_rsp.done) begin
          if (quo_big || spd_raw < wbcs_pkg::SpeedMin) begin
            work_d.forward_speed = wbcs_pkg::SpeedMin;
          end else begin
            work_d.forward_speed = spd_raw;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (state_q == S_IDLE) stride_q <= job_i.stride;
    if (state_q == S_AVG && div_rsp.done) begin
      neg_q <= err < 0;
      mag_q <= MagW'((err < 0) ? -err : err);
    end
    if (state_q == S_MUL) prod_q <= ProdW'(mag_q) * ProdW'(wbcs_pkg::PiQ29);
    if (load_out) out_q <= work_q;
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

`ifndef SYNTHESIS
  a_done_when_waiting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_AVG || state_q == S_TDIV || state_q == S_SDIV))
    else $error("divider result arrived outside a wait state");
  a_seen_speed_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.target_seen) |-> out_q.forward_speed >= wbcs_pkg::SpeedMin)
    else $error("speed below floor with target seen");
  a_unseen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.target_seen) |-> (out_q.turn_rate == '0 &&
      out_q.forward_speed == '0))
    else $error("nonzero command without target");
`endif

endmodule

`default_nettype wire

[rtl/white_blob_centroid_steering.sv]
// Sequencing: the end-of-frame job passes through the queue; for a frame with
//   matches the back end then runs three divider passes before its result leaves.
// Throughput: one byte per cycle within a frame while the job queue is not full;
//   the back end takes one job at a time, the queue absorbing short frames.
// Reset: asynchronous, active low; registers return to stride 1920, match 255,
//   accumulators and queue empty.
// ----------------------------------------------------------------------------
// white_blob_centroid_steering
// Bright-blob centroid tracker producing turn rate and forward speed per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module white_blob_centroid_steering #(
  parameter int unsigned JOB_DEPTH = wbcs_pkg::JobDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  wbcs_stream_if.sink   pix_i,
  wbcs_stream_if.sink   cfg_i,
  wbcs_stream_if.source res_o
);

  logic           push;
  logic           full;
  logic           pop;
  logic           job_valid;
  wbcs_pkg::job_t job_in;
  wbcs_pkg::job_t job_head;

  wbcs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .cfg_i  (cfg_i),
    .push_o (push),
    .job_o  (job_in),
    .full_i (full)
  );

  wbcs_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job_in),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .head_o      (job_head)
  );

  wbcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
